// File: rtl/bsm_pkg.sv
// Shared constants, types and tables of the battery charge monitor.
`default_nettype none

package bsm_pkg;

  localparam int ADC_BITS = 12;
  localparam int VOLT_W   = 16;
  localparam int CHG_W    = 16;
  localparam int LVL_W    = 7;
  localparam int CNT_W    = 8;
  localparam int CFG_DW   = 16;
  localparam int CFG_IW   = 3;
  localparam int EST_W    = 7;
  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 2;
  localparam int MSG_SRCS = 4;

  // Estimate voltages are held in units of 2^-(ADC_BITS+1) mV.
  localparam int HMV_W  = 13;
  localparam int X_W    = ADC_BITS + HMV_W;
  localparam int SEGS   = 12;
  localparam int SEG_IW = $clog2(SEGS);

  typedef logic [HMV_W-1:0] hmv_t;

  localparam hmv_t SEG_HMV [SEGS] = '{
    13'd6300, 13'd6120, 13'd6000, 13'd5895, 13'd5805, 13'd5730,
    13'd5685, 13'd5655, 13'd5595, 13'd5550, 13'd5520, 13'd4950
  };
  localparam logic [EST_W-1:0] SEG_PCT [SEGS] = '{
    7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
    7'd40, 7'd30, 7'd20, 7'd15, 7'd10, 7'd0
  };

  localparam hmv_t ADC_SCALE    = 13'd6600;
  localparam hmv_t CLAMP_HI_CMP = 13'd6300;
  localparam hmv_t CLAMP_HI_SET = 13'd6280;
  localparam hmv_t CLAMP_LO_CMP = 13'd4950;
  localparam hmv_t CLAMP_LO_SET = 13'd4970;
  localparam hmv_t SEG_MARGIN   = 13'd20;
  localparam hmv_t FB_HI        = 13'd6250;
  localparam hmv_t FB_LO        = 13'd4900;
  localparam logic [EST_W-1:0] FB_HP   = 7'd100;
  localparam logic [EST_W-1:0] FB_LP   = 7'd0;
  localparam logic [EST_W-1:0] EST_MAX = 7'd104;

  localparam logic [VOLT_W-1:0] VOLT_LOW_RST     = 16'd8000;
  localparam logic [VOLT_W-1:0] VOLT_HIGH_RST    = 16'd13000;
  localparam logic [LVL_W-1:0]  LOW_LEVEL_RST    = 7'd3;
  localparam logic [CNT_W-1:0]  LOW_TICKS_RST    = 8'd3;
  localparam logic [CNT_W-1:0]  REPORT_RST       = 8'd8;
  localparam logic [LVL_W-1:0]  FORCED_LEVEL_RST = 7'd1;

  localparam logic [CFG_IW-1:0] CFG_VOLT_LOW     = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_VOLT_HIGH    = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_LOW_LEVEL    = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_LOW_TICKS    = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_REPORT       = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_FORCED_LEVEL = 3'd5;

  localparam logic [KIND_W-1:0] KIND_POWEROFF = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BATTERY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHARGE   = 2'd2;

  typedef struct packed {
    logic signed [VOLT_W-1:0] gauge_voltage_mv;
    logic signed [CHG_W-1:0]  gauge_charge;
    logic [ADC_BITS-1:0]      adc_sample;
    logic                     adapter_present;
    logic                     switch_off;
    logic                     board_powered;
    logic                     shutdown_pending;
    logic                     handshake_ok;
  } tick_t;

  typedef struct packed {
    logic [KIND_W-1:0] msg_kind;
    logic [BYTE_W-1:0] byte_a;
    logic [BYTE_W-1:0] byte_b;
    logic              last;
  } msg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EST,
    S_DECIDE,
    S_EMIT
  } top_state_t;

  typedef enum logic [2:0] {
    E_IDLE,
    E_SCALE,
    E_CLAMP,
    E_SEARCH,
    E_MUL_BASE,
    E_MUL_SLOPE,
    E_DIV
  } est_state_t;

  function automatic logic [X_W-1:0] scale_hmv(hmv_t v);
    return {v, {ADC_BITS{1'b0}}};
  endfunction

endpackage

`default_nettype wire

// File: rtl/bsm_if.sv
// Valid/ready channel interfaces for gauge ticks and outgoing messages.
`default_nettype none

interface bsm_tick_if;
  import bsm_pkg::*;
  logic  valid;
  logic  ready;
  tick_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bsm_msg_if;
  import bsm_pkg::*;
  logic valid;
  logic ready;
  msg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/battery_soc_monitor_top.sv
// Battery charge monitor top level: configuration, tick decisions and message queue.
//
//   channel  dir  handshake             payload
//   tick     in   tick.valid/ready      bsm_pkg::tick_t, one gauge tick
//   msg      out  msg.valid/ready       bsm_pkg::msg_t, up to four per tick
//   cfg      in   cfg_we                cfg_index, cfg_wdata
//
// A tick inside the voltage window is accepted, decided on and then emits its messages
// one by one. Outside the window the estimator runs in between: a scale multiply, a
// clamp, a segment search, two multiplies, a restoring divide and a done strobe.
// Ready is high only while the sequencer is idle; the last message may still wait.
// A stalled message output holds the sequencer in its emit state.
// Reset is synchronous and restores register defaults and clears all counters.
`default_nettype none

module battery_soc_monitor_top (
  input  logic                        clk,
  input  logic                        rst,
  bsm_tick_if.sink                    tick,
  bsm_msg_if.source                   msg,
  input  logic                        cfg_we,
  input  logic [bsm_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [bsm_pkg::CFG_DW-1:0]  cfg_wdata
);
  import bsm_pkg::*;

  top_state_t state, state_next;

  logic [VOLT_W-1:0] volt_low_mv, volt_high_mv;
  logic [LVL_W-1:0]  low_charge_level, forced_report_level;
  logic [CNT_W-1:0]  low_charge_ticks, report_period;
  logic [CNT_W-1:0]  low_tick_count, report_count;
  logic              chg_state, cs_old;

  tick_t                   cur;
  logic signed [CHG_W-1:0] soc_val;
  logic [MSG_SRCS-1:0]     pend, pend_new, pend_low, pend_rest;
  logic                    out_valid;
  msg_t                    out_data, msg_sel;

  logic                    tick_ready, accept, oor, est_start, est_done;
  logic                    decide_en, emit_load;
  logic [EST_W-1:0]        est;
  logic signed [VOLT_W:0]  v_ext;
  logic                    qual, po_fire, forced, periodic, change;
  logic [CNT_W-1:0]        lt_inc, lt_next, rc_next;
  logic [BYTE_W-1:0]       soc_byte;

  bsm_estimator u_est (
    .clk     (clk),
    .rst     (rst),
    .start   (est_start),
    .adc     (tick.data.adc_sample),
    .done    (est_done),
    .soc_est (est)
  );

  assign v_ext  = {tick.data.gauge_voltage_mv[VOLT_W-1], tick.data.gauge_voltage_mv};
  assign oor    = (v_ext < $signed({1'b0, volt_low_mv})) ||
                  (v_ext > $signed({1'b0, volt_high_mv}));
  assign accept = tick.valid && tick_ready;

  assign qual = (soc_val <= $signed(CHG_W'(low_charge_level))) && cur.board_powered &&
                !cur.shutdown_pending && cur.handshake_ok && !cur.adapter_present;
  assign lt_inc   = low_tick_count + CNT_W'(1);
  assign po_fire  = qual && (lt_inc >= low_charge_ticks);
  assign lt_next  = qual ? (po_fire ? '0 : lt_inc) : low_tick_count;
  assign forced   = cur.adapter_present &&
                    (cur.switch_off || (soc_val <= $signed(CHG_W'(forced_report_level))));
  assign periodic = (report_count >= report_period);
  assign rc_next  = periodic ? '0 : report_count + CNT_W'(1);
  assign change   = (chg_state != cur.adapter_present);
  assign pend_new = {change, periodic, forced, po_fire};

  assign pend_low  = pend & (~pend + MSG_SRCS'(1));
  assign pend_rest = pend & ~pend_low;
  assign soc_byte  = soc_val[BYTE_W-1:0];

  always_comb begin
    msg_sel.last = (pend_rest == '0);
    if (pend[0]) begin
      msg_sel.msg_kind = KIND_POWEROFF;
      msg_sel.byte_a   = soc_byte;
      msg_sel.byte_b   = '0;
    end else if (pend[1] || pend[2]) begin
      msg_sel.msg_kind = KIND_BATTERY;
      msg_sel.byte_a   = soc_byte;
      msg_sel.byte_b   = BYTE_W'(cs_old);
    end else begin
      msg_sel.msg_kind = KIND_CHARGE;
      msg_sel.byte_a   = BYTE_W'(chg_state);
      msg_sel.byte_b   = BYTE_W'(cs_old);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = oor ? S_EST : S_DECIDE;
      S_EST:    if (est_done) state_next = S_DECIDE;
      S_DECIDE: state_next = (pend_new != '0) ? S_EMIT : S_IDLE;
      S_EMIT:   if (emit_load && (pend_rest == '0)) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    tick_ready = (state == S_IDLE) && !rst;
    est_start  = accept && oor;
    decide_en  = (state == S_DECIDE);
    emit_load  = (state == S_EMIT) && (!out_valid || msg.ready);
  end

  assign tick.ready = tick_ready;
  assign msg.valid  = out_valid;
  assign msg.data   = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      volt_low_mv         <= VOLT_LOW_RST;
      volt_high_mv        <= VOLT_HIGH_RST;
      low_charge_level    <= LOW_LEVEL_RST;
      low_charge_ticks    <= LOW_TICKS_RST;
      report_period       <= REPORT_RST;
      forced_report_level <= FORCED_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VOLT_LOW:     volt_low_mv         <= cfg_wdata[VOLT_W-1:0];
        CFG_VOLT_HIGH:    volt_high_mv        <= cfg_wdata[VOLT_W-1:0];
        CFG_LOW_LEVEL:    low_charge_level    <= cfg_wdata[LVL_W-1:0];
        CFG_LOW_TICKS:    low_charge_ticks    <= cfg_wdata[CNT_W-1:0];
        CFG_REPORT:       report_period       <= cfg_wdata[CNT_W-1:0];
        CFG_FORCED_LEVEL: forced_report_level <= cfg_wdata[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      low_tick_count <= '0;
      report_count   <= '0;
      chg_state      <= 1'b0;
      pend           <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (decide_en) begin
        low_tick_count <= lt_next;
        report_count   <= rc_next;
        chg_state      <= cur.adapter_present;
        pend           <= pend_new;
      end else if (emit_load) begin
        pend <= pend_rest;
      end
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (msg.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur     <= tick.data;
      soc_val <= tick.data.gauge_charge;
    end else if (est_done) begin
      soc_val <= CHG_W'(est);
    end
    if (decide_en) cs_old <= chg_state;
    if (emit_load) out_data <= msg_sel;
  end

`ifndef ASSERT_OFF
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> pend == '0)
    else $error("messages pending while idle");

  a_est_done_state: assert property (@(posedge clk) disable iff (rst)
    est_done |-> state == S_EST)
    else $error("estimate finished outside estimate wait");

  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_EMIT)
    else $error("output loaded outside emit state");
`endif

endmodule

`default_nettype wire

// File: rtl/bsm_estimator.sv
// Charge estimate from the ADC sample: scale, clamp, segment search, interpolation.
`default_nettype none

module bsm_estimator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [bsm_pkg::ADC_BITS-1:0]  adc,
  output logic                          done,
  output logic [bsm_pkg::EST_W-1:0]     soc_est
);
  import bsm_pkg::*;

  localparam int MA_W = X_W + 1;
  localparam int MB_W = HMV_W;
  localparam int P_W  = MA_W + MB_W + 1;
  localparam int Q_W  = 8;
  localparam int QC_W = $clog2(Q_W);

  est_state_t state, state_next;

  logic [ADC_BITS-1:0]     adc_r;
  logic [X_W-1:0]          x;
  hmv_t                    hi, lo;
  logic [EST_W-1:0]        hp, lp;
  logic [SEG_IW-1:0]       k, kp1;
  logic signed [P_W-1:0]   num, prod, num_sum;
  logic [P_W-1:0]          rem, dsh, trial;
  logic                    neg;
  logic [Q_W-1:0]          q;
  logic [QC_W-1:0]         dcnt;
  logic signed [MA_W-1:0]  ma;
  logic [MB_W-1:0]         mb;
  logic [X_W-1:0]          den, seg_hi_s, seg_lo_s;
  logic                    match, ge, last_seg, div_end;

  assign kp1      = k + SEG_IW'(1);
  assign seg_hi_s = scale_hmv(SEG_HMV[k]);
  assign seg_lo_s = scale_hmv(SEG_HMV[kp1] - SEG_MARGIN);
  assign match    = (x < seg_hi_s) && (x > seg_lo_s);
  assign last_seg = (k == SEG_IW'(SEGS - 2));

  assign den     = scale_hmv(hi - lo);
  assign prod    = P_W'(ma) * P_W'($signed({1'b0, mb}));
  assign num_sum = num + prod;
  assign dsh     = P_W'(den) << dcnt;
  assign ge      = (rem >= dsh);
  assign trial   = rem - dsh;
  assign div_end = neg || (dcnt == '0);

  always_comb begin
    state_next = state;
    unique case (state)
      E_IDLE:      if (start) state_next = E_SCALE;
      E_SCALE:     state_next = E_CLAMP;
      E_CLAMP:     state_next = E_SEARCH;
      E_SEARCH:    if (match || last_seg) state_next = E_MUL_BASE;
      E_MUL_BASE:  state_next = E_MUL_SLOPE;
      E_MUL_SLOPE: state_next = E_DIV;
      E_DIV:       if (div_end) state_next = E_IDLE;
      default:     state_next = E_IDLE;
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      E_SCALE: begin
        ma = $signed(MA_W'(adc_r));
        mb = ADC_SCALE;
      end
      E_MUL_BASE: begin
        ma = $signed(MA_W'(den));
        mb = MB_W'(lp);
      end
      E_MUL_SLOPE: begin
        ma = $signed({1'b0, x}) - $signed({1'b0, scale_hmv(lo)});
        mb = MB_W'(hp - lp);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == E_DIV) && div_end;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      E_IDLE: begin
        if (start) adc_r <= adc;
      end
      E_SCALE: begin
        x <= prod[X_W-1:0];
      end
      E_CLAMP: begin
        k <= '0;
        if (x > scale_hmv(CLAMP_HI_CMP)) begin
          x <= scale_hmv(CLAMP_HI_SET);
        end else if (x < scale_hmv(CLAMP_LO_CMP)) begin
          x <= scale_hmv(CLAMP_LO_SET);
        end
      end
      E_SEARCH: begin
        if (match) begin
          hi <= SEG_HMV[k];
          lo <= SEG_HMV[kp1];
          hp <= SEG_PCT[k];
          lp <= SEG_PCT[kp1];
        end else if (last_seg) begin
          hi <= FB_HI;
          lo <= FB_LO;
          hp <= FB_HP;
          lp <= FB_LP;
        end else begin
          k <= kp1;
        end
      end
      E_MUL_BASE: begin
        num <= prod;
      end
      E_MUL_SLOPE: begin
        rem  <= num_sum;
        neg  <= num_sum[P_W-1];
        dcnt <= QC_W'(Q_W - 1);
        q    <= '0;
      end
      E_DIV: begin
        if (ge) rem <= trial;
        q    <= {q[Q_W-2:0], ge};
        dcnt <= dcnt - QC_W'(1);
        if (div_end) begin
          soc_est <= neg ? '0 : EST_W'({q[Q_W-2:0], ge});
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_est_range: assert property (@(posedge clk) disable iff (rst)
    done |-> soc_est <= EST_MAX)
    else $error("estimate above table range");

  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    state == E_SEARCH |-> k <= SEG_IW'(SEGS - 2))
    else $error("segment index past last segment");
`endif

endmodule

`default_nettype wire

// File: sim/battery_soc_monitor_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench: directed and random gauge ticks checked against a message predictor.
module battery_soc_monitor_top_tb;
  import bsm_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_TICKS   = 35;

  localparam logic [CFG_IW-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IW-1:0] CFG_SPARE_7 = 3'd7;

  // Flag order: adapter, switch off, board powered, shutdown pending, handshake ok.
  localparam logic [4:0] FL_NONE       = 5'b00000;
  localparam logic [4:0] FL_LOW_OK     = 5'b00101;
  localparam logic [4:0] FL_ADAPTER    = 5'b10101;
  localparam logic [4:0] FL_SWITCH_OFF = 5'b11101;
  localparam logic [4:0] FL_PENDING    = 5'b00111;
  localparam logic [4:0] FL_NO_SHAKE   = 5'b00100;
  localparam logic [4:0] FL_ALL        = 5'b11111;

  class soc_msg_board;
    logic [VOLT_W-1:0] volt_low, volt_high;
    logic [LVL_W-1:0]  low_level, forced_level;
    logic [CNT_W-1:0]  low_ticks, report_period;
    logic [CNT_W-1:0]  low_tick_cnt, report_cnt;
    logic              chg_state, prev_chg_state;
    // Expected messages, one entry per output transaction.
    msg_t              pending_msgs[$];
    msg_t              tick_msgs[$];
    int                errors;

    function new();
      volt_low       = VOLT_LOW_RST;
      volt_high      = VOLT_HIGH_RST;
      low_level      = LOW_LEVEL_RST;
      low_ticks      = LOW_TICKS_RST;
      report_period  = REPORT_RST;
      forced_level   = FORCED_LEVEL_RST;
      low_tick_cnt   = '0;
      report_cnt     = '0;
      chg_state      = 1'b0;
      prev_chg_state = 1'b0;
      errors         = 0;
    endfunction

    function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        CFG_VOLT_LOW: volt_low = val;
        CFG_VOLT_HIGH: volt_high = val;
        CFG_LOW_LEVEL: low_level = val[LVL_W-1:0];
        CFG_LOW_TICKS: low_ticks = val[CNT_W-1:0];
        CFG_REPORT: report_period = val[CNT_W-1:0];
        CFG_FORCED_LEVEL: forced_level = val[LVL_W-1:0];
        default: ;
      endcase
    endfunction

    function int knee_hmv(int k);
      case (k)
        0: return 6300;
        1: return 6120;
        2: return 6000;
        3: return 5895;
        4: return 5805;
        5: return 5730;
        6: return 5685;
        7: return 5655;
        8: return 5595;
        9: return 5550;
        10: return 5520;
        default: return 4950;
      endcase
    endfunction

    function int knee_pct(int k);
      case (k)
        0: return 100;
        1: return 90;
        2: return 80;
        3: return 70;
        4: return 60;
        5: return 50;
        6: return 40;
        7: return 30;
        8: return 20;
        9: return 15;
        10: return 10;
        default: return 0;
      endcase
    endfunction

    // Voltages are in half-millivolts scaled by 2^ADC_BITS, so the conversion is exact.
    function int charge_estimate(logic [ADC_BITS-1:0] adc);
      longint unit, x, hi, lo, hp, lp, num, den;
      bit     found;
      unit = longint'(1) << ADC_BITS;
      x = longint'(adc) * 6600;
      if (x > 6300 * unit) begin
        x = 6280 * unit;
      end else if (x < 4950 * unit) begin
        x = 4970 * unit;
      end
      hi = 6250 * unit;
      lo = 4900 * unit;
      hp = 100;
      lp = 0;
      found = 1'b0;
      for (int k = 0; k < 11; k++) begin
        if (!found && x < knee_hmv(k) * unit && x > (knee_hmv(k + 1) - 20) * unit) begin
          hi = knee_hmv(k) * unit;
          lo = knee_hmv(k + 1) * unit;
          hp = knee_pct(k);
          lp = knee_pct(k + 1);
          found = 1'b1;
        end
      end
      den = hi - lo;
      num = lp * den + (x - lo) * (hp - lp);
      if (num < 0 || den <= 0) begin
        return 0;
      end
      return int'(num / den);
    endfunction

    function void queue_msg(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] a,
                            logic [BYTE_W-1:0] b);
      msg_t m;
      m.msg_kind = kind;
      m.byte_a   = a;
      m.byte_b   = b;
      m.last     = 1'b0;
      tick_msgs.push_back(m);
    endfunction

    function void note_tick(tick_t t);
      int                volt, soc;
      logic [BYTE_W-1:0] soc_byte;
      msg_t              m;
      volt = $signed(t.gauge_voltage_mv);
      soc  = $signed(t.gauge_charge);
      if (volt < int'(volt_low) || volt > int'(volt_high)) begin
        soc = charge_estimate(t.adc_sample);
      end
      soc_byte = soc[7:0];
      if (soc <= int'(low_level) && t.board_powered && !t.shutdown_pending &&
          t.handshake_ok && !t.adapter_present) begin
        low_tick_cnt = low_tick_cnt + 1'b1;
        if (low_tick_cnt >= low_ticks) begin
          low_tick_cnt = '0;
          queue_msg(KIND_POWEROFF, soc_byte, 8'd0);
        end
      end
      if (t.adapter_present && (t.switch_off || soc <= int'(forced_level))) begin
        queue_msg(KIND_BATTERY, soc_byte, {7'd0, chg_state});
      end
      if (report_cnt >= report_period) begin
        report_cnt = '0;
        queue_msg(KIND_BATTERY, soc_byte, {7'd0, chg_state});
      end else begin
        report_cnt = report_cnt + 1'b1;
      end
      chg_state = t.adapter_present;
      if (prev_chg_state != chg_state) begin
        queue_msg(KIND_CHARGE, {7'd0, chg_state}, {7'd0, prev_chg_state});
        prev_chg_state = chg_state;
      end
      if (tick_msgs.size() > 0) begin
        m = tick_msgs.pop_back();
        m.last = 1'b1;
        tick_msgs.push_back(m);
      end
      foreach (tick_msgs[i]) begin
        pending_msgs.push_back(tick_msgs[i]);
      end
      tick_msgs.delete();
    endfunction

    function void check_msg(msg_t got);
      msg_t want;
      if (pending_msgs.size() == 0) begin
        errors++;
        $display("%0t: unexpected message: expected none,", $time,
                 " actual kind=%0d a=%02h b=%02h last=%0b",
                 got.msg_kind, got.byte_a, got.byte_b, got.last);
      end else begin
        want = pending_msgs.pop_front();
        if (got.msg_kind !== want.msg_kind || got.byte_a !== want.byte_a ||
            got.byte_b !== want.byte_b || got.last !== want.last) begin
          errors++;
          $display("%0t: message mismatch: expected kind=%0d a=%02h b=%02h last=%0b,",
                   $time, want.msg_kind, want.byte_a, want.byte_b, want.last,
                   " actual kind=%0d a=%02h b=%02h last=%0b",
                   got.msg_kind, got.byte_a, got.byte_b, got.last);
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CFG_IW-1:0]   cfg_index;
  logic [CFG_DW-1:0]   cfg_wdata;
  bit                  src_gaps;
  bit                  sink_stalls;
  soc_msg_board        board;

  bsm_tick_if tick_bus ();
  bsm_msg_if  msg_bus ();

  battery_soc_monitor_top u_top (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_bus),
    .msg       (msg_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    msg_bus.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (sink_stalls && $urandom_range(0, 3) == 0) begin
        msg_bus.ready = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      msg_bus.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && msg_bus.valid === 1'b1 && msg_bus.ready === 1'b1) begin
      board.check_msg(msg_bus.data);
    end
  end

  function automatic tick_t make_tick(int volt, int charge, int adc, logic [4:0] flags);
    tick_t t;
    t.gauge_voltage_mv = VOLT_W'(volt);
    t.gauge_charge     = CHG_W'(charge);
    t.adc_sample       = ADC_BITS'(adc);
    {t.adapter_present, t.switch_off, t.board_powered, t.shutdown_pending,
     t.handshake_ok} = flags;
    return t;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    int    lo_mv, hi_mv, pick;
    lo_mv = int'(board.volt_low);
    hi_mv = (int'(board.volt_high) > 32767) ? 32767 : int'(board.volt_high);
    pick = $urandom_range(0, 9);
    if (pick < 5 && lo_mv <= hi_mv) begin
      t.gauge_voltage_mv = VOLT_W'($urandom_range(hi_mv, lo_mv));
    end else if (pick < 7) begin
      t.gauge_voltage_mv = VOLT_W'(lo_mv - int'($urandom_range(1, 200)));
    end else if (pick < 8) begin
      t.gauge_voltage_mv = VOLT_W'(hi_mv + int'($urandom_range(1, 200)));
    end else begin
      t.gauge_voltage_mv = VOLT_W'($urandom);
    end
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      t.gauge_charge = CHG_W'(int'($urandom_range(0, 115)) - 5);
    end else if (pick < 7) begin
      t.gauge_charge = CHG_W'($urandom_range(0, int'(board.low_level) + 3));
    end else begin
      t.gauge_charge = CHG_W'($urandom);
    end
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      t.adc_sample = ADC_BITS'($urandom_range(3060, 3915));
    end else if (pick < 8) begin
      t.adc_sample = ADC_BITS'($urandom);
    end else if (pick < 9) begin
      t.adc_sample = ADC_BITS'($urandom_range(0, 40));
    end else begin
      t.adc_sample = ADC_BITS'($urandom_range(4055, 4095));
    end
    if ($urandom_range(0, 9) < 6) begin
      t.adapter_present  = ($urandom_range(0, 4) == 0);
      t.switch_off       = 1'($urandom_range(0, 1));
      t.board_powered    = 1'b1;
      t.shutdown_pending = 1'b0;
      t.handshake_ok     = 1'b1;
    end else begin
      {t.adapter_present, t.switch_off, t.board_powered, t.shutdown_pending,
       t.handshake_ok} = 5'($urandom);
    end
    return t;
  endfunction

  task automatic drive_tick(tick_t t);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      tick_bus.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    tick_bus.data  = t;
    tick_bus.valid = 1'b1;
    do @(posedge clk); while (tick_bus.ready !== 1'b1);
    board.note_tick(t);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    board.write_reg(idx, val);
  endtask

  task automatic settle();
    tick_bus.valid = 1'b0;
    while (board.pending_msgs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_random(int count);
    repeat (count) drive_tick(random_tick());
    settle();
  endtask

  task automatic shuffle_regs();
    logic [CFG_DW-1:0] lo;
    lo = CFG_DW'($urandom_range(0, 12000));
    cfg_write(CFG_VOLT_LOW, lo);
    cfg_write(CFG_VOLT_HIGH, CFG_DW'(lo + $urandom_range(0, 8000)));
    cfg_write(CFG_LOW_LEVEL, CFG_DW'($urandom_range(0, 100)));
    cfg_write(CFG_LOW_TICKS, CFG_DW'(($urandom_range(0, 3) == 0) ?
                                     $urandom_range(1, 255) : $urandom_range(1, 6)));
    cfg_write(CFG_REPORT, CFG_DW'($urandom_range(0, 12)));
    cfg_write(CFG_FORCED_LEVEL, CFG_DW'($urandom_range(0, 100)));
  endtask

  initial begin
    board          = new();
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    src_gaps       = 1'b0;
    sink_stalls    = 1'b0;
    tick_bus.valid = 1'b0;
    tick_bus.data  = '0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    drive_tick(make_tick(10000, 50, 0, FL_NONE));
    drive_tick(make_tick(8000, 0, 0, FL_LOW_OK));
    drive_tick(make_tick(13000, -1, 0, FL_LOW_OK));
    drive_tick(make_tick(12000, 3, 0, FL_LOW_OK));
    drive_tick(make_tick(7999, 0, 0, FL_NONE));
    drive_tick(make_tick(13001, 0, 4095, FL_NONE));
    drive_tick(make_tick(-32768, 0, 3909, FL_NONE));
    drive_tick(make_tick(32767, 0, 3072, FL_NONE));
    drive_tick(make_tick(10000, -32768, 0, FL_NONE));
    drive_tick(make_tick(10000, 32767, 0, FL_ADAPTER));
    drive_tick(make_tick(10000, 1, 0, FL_ADAPTER));
    drive_tick(make_tick(10000, 80, 0, FL_SWITCH_OFF));
    drive_tick(make_tick(10000, 2, 0, FL_PENDING));
    for (int a = 3100; a <= 3910; a += 90) begin
      drive_tick(make_tick(0, 0, a, FL_LOW_OK));
    end
    drive_tick(make_tick(10000, 2, 0, FL_ALL));
    drive_tick(make_tick(10000, 0, 0, FL_NO_SHAKE));
    settle();

    cfg_write(CFG_VOLT_LOW, 16'd0);
    cfg_write(CFG_VOLT_HIGH, 16'hFFFF);
    cfg_write(CFG_LOW_LEVEL, 16'd100);
    cfg_write(CFG_LOW_TICKS, 16'd1);
    cfg_write(CFG_REPORT, 16'd0);
    cfg_write(CFG_FORCED_LEVEL, 16'd100);
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    run_random(PHASE_TICKS);

    cfg_write(CFG_VOLT_LOW, 16'hFFFF);
    cfg_write(CFG_VOLT_HIGH, 16'd0);
    cfg_write(CFG_LOW_LEVEL, 16'd100);
    cfg_write(CFG_LOW_TICKS, 16'd255);
    cfg_write(CFG_REPORT, 16'd255);
    cfg_write(CFG_FORCED_LEVEL, 16'd0);
    sink_stalls = 1'b0;
    run_random(PHASE_TICKS);

    // The counters run up above are already past these lowered limits.
    cfg_write(CFG_LOW_TICKS, 16'd2);
    cfg_write(CFG_REPORT, 16'd3);
    cfg_write(CFG_VOLT_LOW, 16'd9000);
    cfg_write(CFG_VOLT_HIGH, 16'd12000);
    cfg_write(CFG_LOW_LEVEL, 16'hFFE4);
    cfg_write(CFG_FORCED_LEVEL, 16'hFF8A);
    cfg_write(CFG_SPARE_6, 16'hFFFF);
    cfg_write(CFG_SPARE_7, 16'h0000);
    src_gaps    = 1'b0;
    sink_stalls = 1'b1;
    run_random(PHASE_TICKS);

    cfg_write(CFG_LOW_TICKS, 16'd0);
    cfg_write(CFG_REPORT, 16'd0);
    cfg_write(CFG_LOW_LEVEL, 16'd127);
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    run_random(PHASE_TICKS);

    for (int p = 0; p < 4; p++) begin
      shuffle_regs();
      src_gaps    = (p == 0 || p == 1);
      sink_stalls = (p == 0 || p == 2);
      run_random(PHASE_TICKS);
    end

    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
